// ===== sv/kdb_pkg.sv =====
// Package for the key debounce event detector: phase encoding, event
// struct and reset values of the configuration registers.
// No dependencies.
package kdb_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int CFG_DATA_BITS     = 32;
    localparam int DEBOUNCE_BITS     = 16;
    localparam int CFG_INDEX_BITS    = 2;

    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [CFG_DATA_BITS-1:0] HOLD_REPEAT_RESET = 32'd1000;
    localparam logic [CFG_DATA_BITS-1:0] SHORT_RELEASE_RESET = 32'd1000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEBOUNCE_TIME        = 2'd0,
        CFG_HOLD_REPEAT_INTERVAL = 2'd1,
        CFG_SHORT_RELEASE_LIMIT  = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_FIRST_DOWN = 3'd1,
        PH_DOWN       = 3'd2,
        PH_FIRST_UP   = 3'd3,
        PH_UP         = 3'd4
    } phase_t;

    typedef struct packed {
        logic press;
        logic release_ev;
        logic hold_repeat;
        logic short_release;
        logic held;
    } event_t;

endpackage

// ===== sv/kdb_fsm.sv =====
// Debounce phase machine with mark and press time registers; produces
// the event flags of one scan combinationally. Depends on kdb_pkg.
module kdb_fsm #(
    parameter int TIME_BITS = kdb_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  scan_en,
    input  logic                                  pin_level,
    input  logic [TIME_BITS-1:0]                  now,
    input  logic [kdb_pkg::DEBOUNCE_BITS-1:0]     debounce_time,
    input  logic [kdb_pkg::CFG_DATA_BITS-1:0]     hold_repeat_interval,
    input  logic [kdb_pkg::CFG_DATA_BITS-1:0]     short_release_limit,
    output kdb_pkg::event_t                       events
);

    localparam int CMP_BITS =
        (TIME_BITS > kdb_pkg::CFG_DATA_BITS) ? TIME_BITS : kdb_pkg::CFG_DATA_BITS;

    kdb_pkg::phase_t        phase_reg, phase_next;
    logic [TIME_BITS-1:0]   mark_reg, mark_next;
    logic [TIME_BITS-1:0]   press_time_reg, press_time_next;
    logic [TIME_BITS-1:0]   since_mark, since_press;
    logic                   debounced;
    logic                   press, release_ev;

    // Wrapping differences modulo 2^TIME_BITS.
    assign since_mark  = now - mark_reg;
    assign since_press = now - press_time_reg;
    assign debounced   = CMP_BITS'(since_mark) >= CMP_BITS'(debounce_time);

    always_comb
    begin
        phase_next = kdb_pkg::PH_IDLE;
        case (phase_reg)
            kdb_pkg::PH_FIRST_DOWN:
            begin
                if (pin_level)
                    phase_next = kdb_pkg::PH_IDLE;
                else if (debounced)
                    phase_next = kdb_pkg::PH_DOWN;
                else
                    phase_next = kdb_pkg::PH_FIRST_DOWN;
            end
            kdb_pkg::PH_DOWN:
            begin
                phase_next = pin_level ? kdb_pkg::PH_FIRST_UP : kdb_pkg::PH_DOWN;
            end
            kdb_pkg::PH_FIRST_UP:
            begin
                if (!pin_level)
                    phase_next = kdb_pkg::PH_DOWN;
                else if (debounced)
                    phase_next = kdb_pkg::PH_UP;
                else
                    phase_next = kdb_pkg::PH_FIRST_UP;
            end
            kdb_pkg::PH_UP:
            begin
                phase_next = kdb_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = pin_level ? kdb_pkg::PH_IDLE : kdb_pkg::PH_FIRST_DOWN;
            end
        endcase
    end

    always_comb
    begin
        press      = (phase_reg == kdb_pkg::PH_FIRST_DOWN) &&
                     (phase_next == kdb_pkg::PH_DOWN);
        release_ev = (phase_reg == kdb_pkg::PH_FIRST_UP) &&
                     (phase_next == kdb_pkg::PH_UP);

        events.press      = press;
        events.release_ev = release_ev;
        // On the confirming scan the mark becomes now, and the !press term keeps a repeat from firing.
        events.hold_repeat = (phase_next == kdb_pkg::PH_DOWN) && !press &&
                             (CMP_BITS'(since_mark) > CMP_BITS'(hold_repeat_interval));
        events.short_release = release_ev &&
                             (CMP_BITS'(since_press) < CMP_BITS'(short_release_limit));
        events.held = (phase_next == kdb_pkg::PH_DOWN) ||
                      (phase_next == kdb_pkg::PH_FIRST_UP);

        // Every transition that restarts a period, and each repeat, marks now.
        // Returning from first up to down keeps the mark.
        if (press || release_ev || events.hold_repeat ||
            ((phase_reg == kdb_pkg::PH_DOWN) && pin_level) ||
            ((phase_next == kdb_pkg::PH_FIRST_DOWN) &&
             (phase_reg != kdb_pkg::PH_FIRST_DOWN)))
            mark_next = now;
        else
            mark_next = mark_reg;

        press_time_next = press ? now : press_time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= kdb_pkg::PH_IDLE;
            mark_reg       <= '0;
            press_time_reg <= '0;
        end
        else if (scan_en)
        begin
            phase_reg      <= phase_next;
            mark_reg       <= mark_next;
            press_time_reg <= press_time_next;
        end
    end

endmodule

// ===== sv/key_debounce_event_detector.sv =====
// Top level of the key debounce event detector: scan input register,
// configuration registers and result register. Depends on kdb_pkg, kdb_fsm.
//
// Each scan transaction (pin level and tick time) gives exactly one result
// transaction with press, release, hold-repeat and short-release pulses and
// the held flag. The block takes one scan per clock cycle while the result
// side does not stall; each scan passes through the input register and is
// registered in the result register; the phase update between them sets the rate.
// A stall on the result side holds the result register and then the input
// register. Tick differences wrap modulo 2^TIME_BITS.
module key_debounce_event_detector #(
    parameter int TIME_BITS = kdb_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 pin_level,
    input  logic [31:0]                          now_ticks,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 press_event,
    output logic                                 release_event,
    output logic                                 hold_repeat_event,
    output logic                                 short_release_event,
    output logic                                 is_held,
    input  logic                                 cfg_we,
    input  logic [kdb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [kdb_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    logic [kdb_pkg::DEBOUNCE_BITS-1:0] debounce_reg;
    logic [kdb_pkg::CFG_DATA_BITS-1:0] hold_repeat_reg;
    logic [kdb_pkg::CFG_DATA_BITS-1:0] short_release_reg;

    logic                  scan_valid_reg;
    logic                  pin_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic                  out_valid_reg;
    kdb_pkg::event_t       result_reg;
    kdb_pkg::event_t       events;
    logic                  out_free;
    logic                  scan_en;
    logic                  in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign scan_en  = scan_valid_reg && out_free;
    assign in_stall = scan_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= kdb_pkg::DEBOUNCE_RESET;
            hold_repeat_reg   <= kdb_pkg::HOLD_REPEAT_RESET;
            short_release_reg <= kdb_pkg::SHORT_RELEASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kdb_pkg::CFG_DEBOUNCE_TIME:
                    debounce_reg <= cfg_data[kdb_pkg::DEBOUNCE_BITS-1:0];
                kdb_pkg::CFG_HOLD_REPEAT_INTERVAL:
                    hold_repeat_reg <= cfg_data;
                kdb_pkg::CFG_SHORT_RELEASE_LIMIT:
                    short_release_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                scan_valid_reg <= 1'b1;
            else if (scan_en)
                scan_valid_reg <= 1'b0;

            if (scan_en)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pin_reg <= pin_level;
            now_reg <= TIME_BITS'(now_ticks);
        end
        if (scan_en)
            result_reg <= events;
    end

    kdb_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_fsm (
        .clk                  (clk),
        .rst_n                (rst_n),
        .scan_en              (scan_en),
        .pin_level            (pin_reg),
        .now                  (now_reg),
        .debounce_time        (debounce_reg),
        .hold_repeat_interval (hold_repeat_reg),
        .short_release_limit  (short_release_reg),
        .events               (events)
    );

    assign out_valid           = out_valid_reg;
    assign press_event         = result_reg.press;
    assign release_event       = result_reg.release_ev;
    assign hold_repeat_event   = result_reg.hold_repeat;
    assign short_release_event = result_reg.short_release;
    assign is_held             = result_reg.held;

endmodule

// ===== sv/kdb_checker.sv =====
// Port-level checker for the key debounce event detector, with the bind
// that attaches it to the top level. Depends on key_debounce_event_detector.
module kdb_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic press_event,
    input logic release_event,
    input logic hold_repeat_event,
    input logic short_release_event,
    input logic is_held
);

    // A confirmed press leaves the key held; a confirmed release does not.
    a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && press_event) |-> is_held)
        else $error("press event without held state");

    a_release_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && release_event) |-> (!is_held && !press_event))
        else $error("release event while held or together with press");

    a_short_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && short_release_event) |-> release_event)
        else $error("short release without release");

    a_repeat_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hold_repeat_event) |-> (is_held && !press_event))
        else $error("hold repeat outside the held phase");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(press_event) &&
            $stable(release_event) && $stable(hold_repeat_event) &&
            $stable(short_release_event) && $stable(is_held)))
        else $error("stalled result transaction changed");

endmodule

bind key_debounce_event_detector kdb_checker u_kdb_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .press_event         (press_event),
    .release_event       (release_event),
    .hold_repeat_event   (hold_repeat_event),
    .short_release_event (short_release_event),
    .is_held             (is_held)
);

// ===== tb/sv/kdb_event_checker.sv =====
// Checker for the key debounce event detector: follows the scan and result
// channels and the register port, predicts every result and compares it.
// Depends on kdb_pkg.
module kdb_event_checker
    import kdb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      pin_level,
    input  logic [31:0]               now_ticks,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      press_event,
    input  logic                      release_event,
    input  logic                      hold_repeat_event,
    input  logic                      short_release_event,
    input  logic                      is_held,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        outstanding,
    output int                        fail_count
);

    logic [DEBOUNCE_BITS-1:0] cfg_debounce;
    logic [31:0]              cfg_hold_interval;
    logic [31:0]              cfg_short_limit;

    phase_t      key_phase;
    logic [31:0] mark_tick;
    logic [31:0] press_tick;

    event_t      expected_events[$];

    // Advances the button state by one scan and returns the events it gives.
    function automatic event_t predict_scan(input logic pin, input logic [31:0] now);
        event_t ev;
        ev = '0;
        case (key_phase)
            PH_FIRST_DOWN:
                if (pin)
                    key_phase = PH_IDLE;
                else if (now - mark_tick >= {16'd0, cfg_debounce})
                begin
                    key_phase  = PH_DOWN;
                    mark_tick  = now;
                    press_tick = now;
                    ev.press   = 1'b1;
                end
            PH_DOWN:
                if (pin)
                begin
                    key_phase = PH_FIRST_UP;
                    mark_tick = now;
                end
            PH_FIRST_UP:
                // A bounce back to down keeps the mark taken when the pin went high.
                if (!pin)
                    key_phase = PH_DOWN;
                else if (now - mark_tick >= {16'd0, cfg_debounce})
                begin
                    key_phase     = PH_UP;
                    mark_tick     = now;
                    ev.release_ev = 1'b1;
                end
            PH_UP:
                key_phase = PH_IDLE;
            default:
                if (!pin)
                begin
                    key_phase = PH_FIRST_DOWN;
                    mark_tick = now;
                end
                else
                    key_phase = PH_IDLE;
        endcase
        if (key_phase == PH_DOWN && now - mark_tick > cfg_hold_interval)
        begin
            ev.hold_repeat = 1'b1;
            mark_tick      = now;
        end
        if (ev.release_ev && now - press_tick < cfg_short_limit)
            ev.short_release = 1'b1;
        ev.held = (key_phase == PH_DOWN || key_phase == PH_FIRST_UP);
        return ev;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        event_t exp_ev;
        if (!rst_n)
        begin
            cfg_debounce      = DEBOUNCE_RESET;
            cfg_hold_interval = HOLD_REPEAT_RESET;
            cfg_short_limit   = SHORT_RELEASE_RESET;
            key_phase         = PH_IDLE;
            mark_tick         = '0;
            press_tick        = '0;
            expected_events.delete();
            fail_count        = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE_TIME:        cfg_debounce      = cfg_data[DEBOUNCE_BITS-1:0];
                    CFG_HOLD_REPEAT_INTERVAL: cfg_hold_interval = cfg_data;
                    CFG_SHORT_RELEASE_LIMIT:  cfg_short_limit   = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("result transaction with no scan waiting for it");
                    fail_count++;
                end
                else
                begin
                    exp_ev = expected_events.pop_front();
                    if (press_event !== exp_ev.press)
                    begin
                        $error("press_event: expected %0b, got %0b", exp_ev.press, press_event);
                        fail_count++;
                    end
                    if (release_event !== exp_ev.release_ev)
                    begin
                        $error("release_event: expected %0b, got %0b",
                               exp_ev.release_ev, release_event);
                        fail_count++;
                    end
                    if (hold_repeat_event !== exp_ev.hold_repeat)
                    begin
                        $error("hold_repeat_event: expected %0b, got %0b",
                               exp_ev.hold_repeat, hold_repeat_event);
                        fail_count++;
                    end
                    if (short_release_event !== exp_ev.short_release)
                    begin
                        $error("short_release_event: expected %0b, got %0b",
                               exp_ev.short_release, short_release_event);
                        fail_count++;
                    end
                    if (is_held !== exp_ev.held)
                    begin
                        $error("is_held: expected %0b, got %0b", exp_ev.held, is_held);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_events.push_back(predict_scan(pin_level, now_ticks));
            outstanding <= expected_events.size();
        end
    end

endmodule

// ===== tb/sv/tb_key_debounce_event_detector.sv =====
// Testbench top for the key debounce event detector: clock, reset, scan
// stimulus, register writes and the verdict. Depends on kdb_pkg,
// key_debounce_event_detector and kdb_event_checker.
module tb_key_debounce_event_detector;
    import kdb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      pin_level = 1'b1;
    logic [31:0]               now_ticks = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      press_event;
    logic                      release_event;
    logic                      hold_repeat_event;
    logic                      short_release_event;
    logic                      is_held;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    int outstanding;
    int fail_count;

    // Stimulus shaping: the settings last written, the running tick time,
    // and whether gaps and stalls are on in the current phase.
    logic [15:0] db_set = DEBOUNCE_RESET;
    logic [31:0] hold_set = HOLD_REPEAT_RESET;
    logic [31:0] short_set = SHORT_RELEASE_RESET;
    logic [31:0] tick_now = '0;
    bit          gaps_on = 1'b0;
    bit          stalls_on = 1'b0;
    int          scans_sent = 0;
    int          cycles = 0;
    int          stall_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    key_debounce_event_detector dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .pin_level           (pin_level),
        .now_ticks           (now_ticks),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .press_event         (press_event),
        .release_event       (release_event),
        .hold_repeat_event   (hold_repeat_event),
        .short_release_event (short_release_event),
        .is_held             (is_held),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    kdb_event_checker event_chk (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .pin_level           (pin_level),
        .now_ticks           (now_ticks),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .press_event         (press_event),
        .release_event       (release_event),
        .hold_repeat_event   (hold_repeat_event),
        .short_release_event (short_release_event),
        .is_held             (is_held),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .outstanding         (outstanding),
        .fail_count          (fail_count)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_key_debounce_event_detector: errors");
            $finish;
        end
    end

    // Result-side back pressure: mostly short stalls, now and then a long one.
    always @(posedge clk)
    begin : stall_gen
        int r;
        r = $urandom_range(0, 99);
        if (!stalls_on)
            out_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (r < 65)
            out_stall <= 1'b0;
        else if (r < 95)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(8, 30);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Time advance per scan, scaled to one of the configured intervals so that
    // the debounce, hold-repeat and short-release thresholds are all crossed.
    function automatic logic [31:0] pick_step();
        logic [31:0] span;
        int          r;
        r = $urandom_range(0, 15);
        if (r < 8)
            span = {16'd0, db_set};
        else if (r < 12)
            span = hold_set;
        else
            span = short_set;
        if (span > 32'h4000_0000)
            span = 32'h4000_0000;
        if (r == 7)
            return span;
        if (r == 11)
            return span + 32'd1;
        return $urandom_range(0, span / 3 + 1);
    endfunction

    task automatic send_scan(input logic pin, input logic [31:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= pin;
        now_ticks <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        scans_sent++;
    endtask

    task automatic scan_step(input logic pin);
        tick_now = tick_now + pick_step();
        send_scan(pin, tick_now);
    endtask

    // One press of the button: bounce, hold low, bounce, settle high.
    task automatic play_press();
        int n;
        n = $urandom_range(0, 3);
        repeat (n) scan_step(1'($urandom_range(0, 1)));
        n = $urandom_range(2, 10);
        repeat (n) scan_step(1'b0);
        n = $urandom_range(0, 3);
        repeat (n) scan_step(1'($urandom_range(0, 1)));
        n = $urandom_range(1, 5);
        repeat (n) scan_step(1'b1);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int n;
        stop_at   = scans_sent + count;
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
        while (scans_sent < stop_at)
        begin
            if ($urandom_range(0, 4) != 0)
                play_press();
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 5) == 0)
                        tick_now = $urandom;
                    scan_step(1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // Waits until every scan has its result and the pipeline is empty.
    // The first edge lets the count take in the scan accepted last.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] db, input logic [31:0] hold,
                              input logic [31:0] short_lim);
        write_reg(CFG_DEBOUNCE_TIME, db);
        write_reg(CFG_HOLD_REPEAT_INTERVAL, hold);
        write_reg(CFG_SHORT_RELEASE_LIMIT, short_lim);
        db_set    = db[15:0];
        hold_set  = hold;
        short_set = short_lim;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: debounce 20, hold repeat 1000, short release 1000.
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_scan(1'b1, 32'd0);
        send_scan(1'b0, 32'd5);
        send_scan(1'b0, 32'd10);
        send_scan(1'b1, 32'd12);            // bounce while first down
        send_scan(1'b0, 32'd30);
        send_scan(1'b0, 32'd50);            // press exactly at the debounce time
        send_scan(1'b0, 32'd600);
        send_scan(1'b1, 32'd700);
        send_scan(1'b0, 32'd710);           // bounce back to down
        send_scan(1'b0, 32'd1701);          // hold repeat counted from the mark at 700
        send_scan(1'b0, 32'd2701);          // exactly the interval: no repeat
        send_scan(1'b0, 32'd2702);
        send_scan(1'b1, 32'd2800);
        send_scan(1'b1, 32'd2820);          // long release
        send_scan(1'b0, 32'd2821);          // up phase ignores the pin
        send_scan(1'b0, 32'hFFFF_FFF0);
        send_scan(1'b0, 32'h0000_0004);     // press across the tick wrap
        send_scan(1'b1, 32'h0000_0010);
        send_scan(1'b1, 32'h0000_0024);     // short release
        send_scan(1'b1, 32'hFFFF_FFFF);
        send_scan(1'b1, 32'hFFFF_FFFF);
        drain();

        set_config(32'd0, 32'd0, 32'hFFFF_FFFF);
        run_random(80);
        drain();

        set_config(32'h0000_FFFF, 32'hFFFF_FFFF, 32'd0);
        run_random(80);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            set_config($urandom_range(0, 40), $urandom_range(0, 400), $urandom_range(0, 600));
            tick_now = (p == 1) ? 32'hFFFF_F000 : $urandom;
            run_random(110);
            drain();
        end

        set_config($urandom, $urandom, $urandom);
        run_random(100);
        drain();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("tb_key_debounce_event_detector: clean");
        else
            $display("tb_key_debounce_event_detector: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/kdb_pkg.sv
sv/kdb_fsm.sv
sv/key_debounce_event_detector.sv
sv/kdb_checker.sv
tb/sv/kdb_event_checker.sv
tb/sv/tb_key_debounce_event_detector.sv
